@@ src/rtt_deviation_congestion_window_defines.svh @@
// assertion macros for the rtt deviation congestion window block
// used by the top level, no other dependencies
`ifndef RTT_DEVIATION_CONGESTION_WINDOW_DEFINES_SVH
`define RTT_DEVIATION_CONGESTION_WINDOW_DEFINES_SVH

// invariant checked at every edge out of reset
`define RDCW_ASSERT_ALWAYS(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("invariant violated");

// next-cycle implication
`define RDCW_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sequence violated");

`endif

@@ src/rdcw_pkg.sv @@
// package for the rtt deviation congestion window block
// holds constants, state type and helpers; no dependencies
package rdcw_pkg;

	localparam int unsigned HISTORY_DEPTH_DEF = 50;
	localparam int unsigned LIMIT_FLOOR = 10;
	localparam int unsigned LIMIT_RESET = 20;
	localparam int unsigned CHANGE_MIN_US = 100;
	localparam int unsigned RTT_W = 24;
	localparam int unsigned DIV_W = 48;
	localparam int unsigned DVS_W = 32;
	localparam logic [31:0] INIT_THR_RESET = 32'd256000;
	localparam logic [31:0] TIME_WIN_RESET = 32'd10000;

	localparam logic OP_ACK = 1'b0;
	localparam logic OP_WIN = 1'b1;

	localparam logic REG_INIT_THR = 1'b0;
	localparam logic REG_TIME_WIN = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WALK_RD,
		ST_WALK_ACC,
		ST_DEV_DIV,
		ST_PUSH,
		ST_WIN_EVAL,
		ST_SEV_DIV,
		ST_F_DIV,
		ST_G_DIV,
		ST_REDUCE,
		ST_DECAY_DIV,
		ST_DECAY_FIX,
		ST_INCREASE,
		ST_DONE
	} state_t;

	function automatic logic [31:0] sat32(input logic [47:0] v);
		sat32 = (v > 48'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	// floor(x / 5) for 16-bit x by reciprocal multiplication
	function automatic logic [15:0] div5_16(input logic [15:0] x);
		logic [33:0] p;
		p = {18'b0, x} * 34'd52429;
		div5_16 = p[33:18];
	endfunction

endpackage

@@ src/rtt_deviation_congestion_window.sv @@
// ack: walk the n-sample history when a deviation is due, divide if any sample counted, push
// window: congestion divides for severity and cuts, else decay at zero deviation, then increase
// throughput: one item at a time; a finished result waits in the output register
// reset: arst_n clears all control state, history empty, limit 20, threshold from register
// top level of the rtt deviation congestion window block
// depends on rdcw_pkg, rdcw_div, rdcw_hist and the defines header
`include "rtt_deviation_congestion_window_defines.svh"
module rtt_deviation_congestion_window import rdcw_pkg::*; #(
	parameter int unsigned HISTORY_DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [31:0] now_us,
	input  logic [23:0] rtt_us,
	input  logic [31:0] cwnd_in,
	input  logic [31:0] ssthresh_in,
	input  logic [15:0] segment_size,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] cwnd_out,
	output logic [31:0] ssthresh_out,
	output logic        congestion_seen,
	output logic [31:0] rtt_deviation,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int unsigned PTR_W = $clog2(HISTORY_DEPTH);
	localparam int unsigned CNT_W = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned WGT_W = $clog2(LIMIT_FLOOR + HISTORY_DEPTH + 1);
	localparam int unsigned TOT_W = WGT_W + CNT_W;
	localparam int unsigned SUM_W = RTT_W + TOT_W;
	localparam int unsigned LIM_RST = (LIMIT_RESET < HISTORY_DEPTH) ? LIMIT_RESET
		: HISTORY_DEPTH;

	state_t state_q, state_d;

	logic [31:0] cwnd_q, ssth_q;
	logic [23:0] rtt_q;
	logic [15:0] seg_q;
	logic [23:0] min_rtt_q;
	logic [CNT_W-1:0] count_q, limit_q, idx_q;
	logic [PTR_W-1:0] head_q, rp_q;
	logic [31:0] dev_q, cached_q, last_comp_q, last_ref_q, thr_q, init_thr_q, win_q;
	logic [WGT_W-1:0] wgt_q;
	logic [TOT_W-1:0] tot_q;
	logic [SUM_W-1:0] sum_q;
	logic [15:0] sev_q;
	logic [8:0]  f_q;
	logic [33:0] c_q;
	logic [31:0] ssres_q;
	logic [31:0] dec_q;
	logic        seen_q, by_wr_q, launched_q;
	logic        out_valid_q;
	logic [31:0] out_cwnd_q, out_ss_q, out_dev_q;
	logic        out_seen_q;

	logic             div_start, div_done;
	logic [DIV_W-1:0] div_dvd, div_q;
	logic [31:0]      div_dvs;
	logic             mem_rd, mem_wr;
	logic [23:0]      mem_rdata;

	logic        accept, cfg_wr, out_load;
	logic        due_comp, due_ref;
	logic        by_window, by_dev, by_rtt, cong;
	logic [23:0] diff;
	logic [CNT_W:0] n_cnt;
	logic signed [35:0] dsig;
	logic [17:0] sev3;
	logic [15:0] f_t5, f_t15, g_t;
	logic [9:0]  g_f;
	logic [63:0] dec_prod;
	logic [31:0] dec_ten, dec_rem, dec_nine;

	assign accept = in_valid && in_ready;
	assign in_ready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_TIME_WIN) ? win_q : init_thr_q;

	assign due_comp = (now_us - last_comp_q) >= win_q;
	assign due_ref = (now_us - last_ref_q) >= win_q;
	assign by_window = cwnd_q > ssth_q;
	assign by_dev = cached_q > thr_q;
	assign by_rtt = ({3'b0, rtt_q} * 27'd5) > ({3'b0, min_rtt_q} * 27'd6);
	assign cong = by_window || by_dev || by_rtt;
	assign diff = (rtt_q > mem_rdata) ? (rtt_q - mem_rdata) : (mem_rdata - rtt_q);
	assign n_cnt = {1'b0, count_q} + 1'b1;
	assign dsig = $signed({2'b0, c_q}) - $signed({4'b0, ssth_q});

	// severity scaling by reciprocal multiplication
	assign sev3 = {1'b0, sev_q, 1'b0} + {2'b0, sev_q};
	assign f_t5 = div5_16({2'b0, sev_q[15:2]});
	assign f_t15 = div5_16(sev3[17:2]);
	assign g_t = div5_16(sev_q);
	assign g_f = (g_t > 16'd256) ? 10'd512 : 10'd256 + g_t[9:0];

	// threshold decay: thr = 10q + r, result 9q + max(r - 1, 0)
	assign dec_prod = {32'b0, thr_q} * 64'h0000_0000_CCCC_CCCD;
	assign dec_ten = 32'({dec_q, 3'b0}) + 32'({dec_q, 1'b0});
	assign dec_rem = thr_q - dec_ten;
	assign dec_nine = 32'({dec_q, 3'b0}) + dec_q;

	rdcw_div #(.W(DIV_W), .DW(DVS_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_q)
	);

	rdcw_hist #(.DEPTH(HISTORY_DEPTH)) u_hist (
		.clk     (clk),
		.wr_en   (mem_wr),
		.wr_addr (head_q),
		.wr_data (rtt_q),
		.rd_en   (mem_rd),
		.rd_addr (rp_q),
		.rd_data (mem_rdata)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (operation == OP_WIN) state_d = ST_WIN_EVAL;
					else if (due_comp) state_d = ST_WALK_RD;
					else state_d = ST_PUSH;
				end
			end
			ST_WALK_RD: begin
				if (idx_q == count_q) state_d = (tot_q == '0) ? ST_PUSH : ST_DEV_DIV;
				else state_d = ST_WALK_ACC;
			end
			ST_WALK_ACC: state_d = ST_WALK_RD;
			ST_DEV_DIV: if (div_done) state_d = ST_PUSH;
			ST_PUSH: state_d = ST_DONE;
			ST_WIN_EVAL: begin
				if (cong) state_d = ST_SEV_DIV;
				else if (cached_q == '0) state_d = ST_DECAY_DIV;
				else state_d = ST_INCREASE;
			end
			ST_SEV_DIV: if (div_done) state_d = ST_F_DIV;
			ST_F_DIV: state_d = ST_G_DIV;
			ST_G_DIV: state_d = ST_REDUCE;
			ST_REDUCE: state_d = ST_DONE;
			ST_DECAY_DIV: state_d = ST_DECAY_FIX;
			ST_DECAY_FIX: state_d = ST_INCREASE;
			ST_INCREASE: state_d = ST_DONE;
			ST_DONE: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// unit controls
	always_comb begin
		div_dvd = '0;
		div_dvs = 32'd1;
		mem_rd = 1'b0;
		mem_wr = 1'b0;
		unique case (state_q)
			ST_WALK_RD: mem_rd = (idx_q != count_q);
			ST_DEV_DIV: begin
				div_dvd = DIV_W'({sum_q, 8'b0});
				div_dvs = 32'(tot_q);
			end
			ST_PUSH: mem_wr = 1'b1;
			ST_SEV_DIV: begin
				div_dvd = DIV_W'({cached_q, 8'b0});
				div_dvs = (thr_q == '0) ? 32'd1 : thr_q;
			end
			default: begin
			end
		endcase
		div_start = ((state_q == ST_DEV_DIV) || (state_q == ST_SEV_DIV)) && !launched_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			launched_q <= 1'b0;
			out_valid_q <= 1'b0;
			min_rtt_q <= '0;
			count_q <= '0;
			head_q <= '0;
			limit_q <= CNT_W'(LIM_RST);
			dev_q <= '0;
			cached_q <= '0;
			last_comp_q <= '0;
			last_ref_q <= '0;
			thr_q <= INIT_THR_RESET;
			init_thr_q <= INIT_THR_RESET;
			win_q <= TIME_WIN_RESET;
		end else begin
			state_q <= state_d;
			if (div_start) launched_q <= 1'b1;
			else if (div_done) launched_q <= 1'b0;
			out_valid_q <= out_load || (out_valid_q && !out_ready);
			if (cfg_wr) begin
				if (paddr[2] == REG_INIT_THR) begin
					init_thr_q <= pwdata;
					thr_q <= pwdata;
				end else begin
					win_q <= pwdata;
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (operation == OP_ACK) begin
							if (min_rtt_q == '0 || rtt_us < min_rtt_q) min_rtt_q <= rtt_us;
							if (due_comp) last_comp_q <= now_us;
						end else if (due_ref) begin
							cached_q <= dev_q;
							last_ref_q <= now_us;
						end
					end
				end
				ST_WALK_RD: begin
					if (idx_q == count_q && tot_q == '0) dev_q <= '0;
				end
				ST_DEV_DIV: if (div_done) dev_q <= div_q[31:0];
				ST_PUSH: begin
					head_q <= (head_q == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : head_q + 1'b1;
					if (n_cnt > {1'b0, limit_q}) count_q <= count_q;
					else if (n_cnt > (CNT_W+1)'(HISTORY_DEPTH)) count_q <= CNT_W'(HISTORY_DEPTH);
					else count_q <= n_cnt[CNT_W-1:0];
					if (dev_q > thr_q) begin
						if (limit_q < CNT_W'(HISTORY_DEPTH)) limit_q <= limit_q + 1'b1;
					end else begin
						if (limit_q > CNT_W'(LIMIT_FLOOR)) limit_q <= limit_q - 1'b1;
					end
				end
				ST_G_DIV: begin
					thr_q <= sat32(48'(({10'b0, thr_q} * 42'(g_f)) >> 8));
				end
				ST_DECAY_FIX: begin
					thr_q <= dec_nine + ((dec_rem == '0) ? 32'd0 : dec_rem - 32'd1);
				end
				default: begin
				end
			endcase
		end
	end

	// item datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					rtt_q <= rtt_us;
					cwnd_q <= cwnd_in;
					ssth_q <= ssthresh_in;
					seg_q <= segment_size;
					c_q <= {2'b0, cwnd_in};
					ssres_q <= ssthresh_in;
					seen_q <= 1'b0;
					idx_q <= '0;
					rp_q <= (head_q == '0) ? PTR_W'(HISTORY_DEPTH - 1) : head_q - 1'b1;
					wgt_q <= WGT_W'(LIMIT_FLOOR);
					tot_q <= '0;
					sum_q <= '0;
				end
			end
			ST_WALK_ACC: begin
				idx_q <= idx_q + 1'b1;
				rp_q <= (rp_q == '0) ? PTR_W'(HISTORY_DEPTH - 1) : rp_q - 1'b1;
				if (diff > 24'(CHANGE_MIN_US)) begin
					sum_q <= sum_q + SUM_W'({6'b0, diff} * 30'(wgt_q));
					tot_q <= tot_q + TOT_W'(wgt_q);
					wgt_q <= wgt_q + 1'b1;
				end
			end
			ST_WIN_EVAL: begin
				by_wr_q <= by_window || by_rtt;
				if (!cong && cached_q == '0) begin
					c_q <= ({2'b0, cwnd_q} + 34'({18'b0, seg_q} * 34'd15) > 34'hFFFF_FFFF)
						? 34'hFFFF_FFFF : {2'b0, cwnd_q} + 34'({18'b0, seg_q} * 34'd15);
				end
			end
			ST_SEV_DIV: begin
				if (div_done) sev_q <= (div_q > 48'hFFFF) ? 16'hFFFF : div_q[15:0];
			end
			ST_F_DIV: begin
				if (by_wr_q) f_q <= (f_t5 >= 16'd51) ? 9'd205 : 9'd256 - f_t5[8:0];
				else f_q <= (f_t15 >= 16'd77) ? 9'd179 : 9'd256 - f_t15[8:0];
			end
			ST_DECAY_DIV: begin
				dec_q <= {3'b0, dec_prod[63:35]};
			end
			ST_REDUCE: begin
				c_q <= (41'(({9'b0, cwnd_q} * 41'(f_q)) >> 8) < 41'({25'b0, seg_q} * 41'd10))
					? 34'({18'b0, seg_q} * 34'd10)
					: 34'(({9'b0, cwnd_q} * 41'(f_q)) >> 8);
				ssres_q <= sat32(48'((41'(({9'b0, cwnd_q} * 41'(f_q)) >> 8) <
					41'({25'b0, seg_q} * 41'd10)) ? 41'({25'b0, seg_q} * 41'd10)
					: 41'(({9'b0, cwnd_q} * 41'(f_q)) >> 8)));
				seen_q <= 1'b1;
			end
			ST_INCREASE: begin
				if (dsig < $signed({20'b0, seg_q})) begin
					c_q <= c_q + 34'({18'b0, seg_q} * 34'd7);
				end else if (dsig >= $signed({18'b0, seg_q, 2'b0})) begin
					c_q <= (c_q > {18'b0, seg_q}) ? c_q - {18'b0, seg_q} : '0;
				end else begin
					c_q <= (c_q + ((c_q[33:1] == '0) ? 34'd1 : {1'b0, c_q[33:1]})
						> {2'b0, ssth_q}) ? {2'b0, ssth_q}
						: c_q + ((c_q[33:1] == '0) ? 34'd1 : {1'b0, c_q[33:1]});
				end
			end
			ST_DONE: begin
				if (out_load) begin
					out_cwnd_q <= sat32({14'b0, c_q});
					out_ss_q <= ssres_q;
					out_seen_q <= seen_q;
					out_dev_q <= dev_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid = out_valid_q;
	assign cwnd_out = out_cwnd_q;
	assign ssthresh_out = out_ss_q;
	assign congestion_seen = out_seen_q;
	assign rtt_deviation = out_dev_q;

	`RDCW_ASSERT_ALWAYS(a_count_cap, count_q <= CNT_W'(HISTORY_DEPTH))
	`RDCW_ASSERT_ALWAYS(a_limit_range, limit_q >= CNT_W'(LIMIT_FLOOR) && limit_q <= CNT_W'(HISTORY_DEPTH))
	`RDCW_ASSERT_ALWAYS(a_done_launched, !div_done || launched_q)
	`RDCW_ASSERT_NEXT(a_done_to_out, out_load, out_valid_q && state_q == ST_IDLE)

endmodule

@@ src/rdcw_div.sv @@
// shared restoring divider, one quotient bit per cycle
// depends on rdcw_pkg
module rdcw_div import rdcw_pkg::*; #(
	parameter int unsigned W = DIV_W,
	parameter int unsigned DW = DVS_W
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [W-1:0]  dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [W-1:0]  quotient
);

	localparam int unsigned CW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [DW:0]   rem_q;
	logic [W-1:0]  dq_q;
	logic [DW-1:0] dvs_q;
	logic [DW:0]   trial;
	logic          ge;

	always_comb begin
		trial = {rem_q[DW-1:0], dq_q[W-1]};
		ge = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dq_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? (trial - {1'b0, dvs_q}) : trial;
			dq_q <= {dq_q[W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = dq_q;

endmodule

@@ src/rdcw_hist.sv @@
// rtt history memory, one write and one registered read per cycle
// depends on rdcw_pkg
module rdcw_hist import rdcw_pkg::*; #(
	parameter int unsigned DEPTH = HISTORY_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [RTT_W-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [RTT_W-1:0]         rd_data
);

	logic [RTT_W-1:0] mem [DEPTH];
	logic [RTT_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

@@ dv/rtt_deviation_congestion_window_test.sv @@
`timescale 1ns / 1ps
// testbench for rtt_deviation_congestion_window: directed table then random acks and window updates
// scoreboarded against an in-bench predictor; depends on rdcw_pkg and the block rtl
module rtt_deviation_congestion_window_test;
	import rdcw_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        operation;
	logic [31:0] now_us;
	logic [23:0] rtt_us;
	logic [31:0] cwnd_in;
	logic [31:0] ssthresh_in;
	logic [15:0] segment_size;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] cwnd_out;
	logic [31:0] ssthresh_out;
	logic        congestion_seen;
	logic [31:0] rtt_deviation;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	localparam int DEPTH = HISTORY_DEPTH_DEF;

	typedef struct packed {
		logic        op;
		logic [31:0] now;
		logic [23:0] rtt;
		logic [31:0] cwnd;
		logic [31:0] ssth;
		logic [15:0] seg;
	} sample_t;

	typedef struct packed {
		logic [31:0] cwnd;
		logic [31:0] ssth;
		logic        seen;
		logic [31:0] dev;
	} window_t;

	typedef struct {
		sample_t s;
		logic    known;
		window_t w;
	} row_t;

	// predictor state
	logic [31:0] p_init_thr, p_time_win, p_min_rtt, p_count, p_head, p_limit;
	logic [31:0] p_dev, p_cached, p_last_comp, p_last_ref, p_thr;
	logic [23:0] p_hist [DEPTH];

	window_t expected_windows [$];
	sample_t send_queue [$];
	row_t    directed [$];
	int      errors;
	int      n_acks, n_wins, n_congest;
	int      idle_cycles;
	int      phase_now;
	int      hold_left;
	bit      held;
	bit      in_beat;
	bit      no_idle, sending;

	rtt_deviation_congestion_window u_top (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] sat(input logic [63:0] v);
		return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	function automatic logic [31:0] weighted_deviation(input logic [23:0] rtt);
		logic [63:0] sum, total, weight;
		logic [31:0] idx, d;
		sum = 0;
		total = 0;
		weight = 10;
		for (int i = 0; i < p_count && i < DEPTH; i++) begin
			idx = (p_head >= i + 1) ? p_head - (i + 1) : p_head + DEPTH - (i + 1);
			d = (rtt > p_hist[idx]) ? rtt - p_hist[idx] : p_hist[idx] - rtt;
			if (d > CHANGE_MIN_US) begin
				sum += d * weight;
				total += weight;
				weight++;
			end
		end
		if (total == 0)
			return 0;
		return sat((sum * 256) / total);
	endfunction

	function automatic window_t predict_window(input sample_t s);
		window_t w;
		logic [63:0] c, sev, f, g, t, nc, inc;
		logic [31:0] thr, n;
		logic by_w, by_d, by_r;
		longint d;
		w.cwnd = s.cwnd;
		w.ssth = s.ssth;
		w.seen = 1'b0;
		if (s.op == OP_ACK) begin
			if (p_min_rtt == 0 || s.rtt < p_min_rtt)
				p_min_rtt = s.rtt;
			if (s.now - p_last_comp >= p_time_win) begin
				p_dev = weighted_deviation(s.rtt);
				p_last_comp = s.now;
			end
			p_hist[p_head] = s.rtt;
			p_head = (p_head + 1 >= DEPTH) ? 0 : p_head + 1;
			n = p_count + 1;
			if (n > p_limit)
				n--;
			if (n > DEPTH)
				n = DEPTH;
			p_count = n;
			if (p_dev > p_thr) begin
				if (p_limit < DEPTH)
					p_limit++;
			end else if (p_limit > LIMIT_FLOOR) begin
				p_limit--;
			end
		end else begin
			c = s.cwnd;
			if (s.now - p_last_ref >= p_time_win) begin
				p_cached = p_dev;
				p_last_ref = s.now;
			end
			by_w = s.cwnd > s.ssth;
			by_d = p_cached > p_thr;
			by_r = 64'(s.rtt) * 5 > 64'(p_min_rtt) * 6;
			if (by_w || by_d || by_r) begin
				thr = p_thr ? p_thr : 1;
				sev = (64'(p_cached) * 256) / thr;
				if (sev > 64'hFFFF)
					sev = 64'hFFFF;
				if (by_w || by_r) begin
					t = sev * 5 / 100;
					f = (t >= 51) ? 205 : 256 - t;
				end else begin
					t = sev * 15 / 100;
					f = (t >= 77) ? 179 : 256 - t;
				end
				nc = (c * f) >> 8;
				if (nc < 64'(s.seg) * 10)
					nc = 64'(s.seg) * 10;
				g = 256 + sev * 20 / 100;
				if (g > 512)
					g = 512;
				p_thr = sat((64'(p_thr) * g) >> 8);
				w.cwnd = sat(nc);
				w.ssth = sat(nc);
				w.seen = 1'b1;
			end else begin
				if (p_cached == 0) begin
					c += 64'(s.seg) * 15;
					if (c > 64'hFFFF_FFFF)
						c = 64'hFFFF_FFFF;
					p_thr = (64'(p_thr) * 9) / 10;
				end
				d = longint'(c) - longint'(s.ssth);
				if (d < longint'(s.seg)) begin
					c += 64'(s.seg) * 7;
				end else if (d >= longint'(s.seg) * 4) begin
					c = (c > s.seg) ? c - s.seg : 0;
				end else begin
					inc = c / 2;
					if (inc < 1)
						inc = 1;
					c += inc;
					if (c > s.ssth)
						c = s.ssth;
				end
				w.cwnd = sat(c);
			end
		end
		w.dev = p_dev;
		return w;
	endfunction

	task automatic write_register(input logic idx, input logic [31:0] value);
		@(negedge clk);
		psel = 1'b1;
		pwrite = 1'b1;
		penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = value;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		if (idx == REG_INIT_THR) begin
			p_init_thr = value;
			p_thr = value;
		end else begin
			p_time_win = value;
		end
	endtask

	task automatic drain;
		while (send_queue.size() != 0 || expected_windows.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	function automatic sample_t random_sample(input logic [31:0] now);
		sample_t s;
		int r;
		s.op = 1'($urandom_range(0, 1));
		s.now = now;
		r = $urandom_range(0, 9);
		s.rtt = (r == 0) ? 24'($urandom) : (r < 3) ? 24'($urandom_range(0, 300))
			: 24'($urandom_range(20000, 60000));
		r = $urandom_range(0, 9);
		s.seg = (r == 0) ? 16'($urandom) : 16'($urandom_range(500, 1500));
		s.ssth = (r == 1) ? $urandom : $urandom_range(10000, 400000);
		s.cwnd = (r == 2) ? $urandom : $urandom_range(5000, 400000);
		return s;
	endfunction

	// sender: a beat stays offered until it is taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_beat) begin
				if (send_queue.size() != 0 && (no_idle || $urandom_range(0, 99) >= 36)) begin
					in_valid <= 1'b1;
					{operation, now_us, rtt_us, cwnd_in, ssthresh_in, segment_size}
						<= send_queue[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver, with one long hold-off in the pressure phase
	always @(negedge clk) begin
		if (phase_now == 4 && !held) begin
			held = 1'b1;
			hold_left = 400;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= no_idle || ($urandom_range(0, 99) >= 36);
		end
	end

	always @(posedge clk) begin
		window_t w;
		row_t r;
		in_beat = arst_n && in_valid && in_ready;
		if (in_beat) begin
			w = predict_window({operation, now_us, rtt_us, cwnd_in, ssthresh_in, segment_size});
			expected_windows = {expected_windows, w};
			send_queue.delete(0);
			if (operation == OP_ACK)
				n_acks++;
			else
				n_wins++;
		end
		if (arst_n && out_valid && out_ready) begin
			if (expected_windows.size() == 0) begin
				$display("%0t unexpected result beat cwnd %h", $time, cwnd_out);
				errors++;
			end else begin
				w = expected_windows[0];
				expected_windows.delete(0);
				if (w.seen)
					n_congest++;
				if (cwnd_out !== w.cwnd) begin
					$display("%0t cwnd_out expected %h actual %h", $time, w.cwnd, cwnd_out);
					errors++;
				end
				if (ssthresh_out !== w.ssth) begin
					$display("%0t ssthresh_out expected %h actual %h", $time, w.ssth,
						ssthresh_out);
					errors++;
				end
				if (congestion_seen !== w.seen) begin
					$display("%0t congestion_seen expected %b actual %b", $time, w.seen,
						congestion_seen);
					errors++;
				end
				if (rtt_deviation !== w.dev) begin
					$display("%0t rtt_deviation expected %h actual %h", $time, w.dev,
						rtt_deviation);
					errors++;
				end
			end
			// directed rows checked against typed results as well
			if (directed.size() != 0 && sending) begin
				r = directed[0];
				directed.delete(0);
				if (r.known && {cwnd_out, ssthresh_out, congestion_seen, rtt_deviation} !== r.w) begin
					$display("%0t directed row expected %h actual %h", $time, r.w,
						{cwnd_out, ssthresh_out, congestion_seen, rtt_deviation});
					errors++;
				end
			end
		end
		if (arst_n && !((in_valid && in_ready) || (out_valid && out_ready)))
			idle_cycles++;
		else
			idle_cycles = 0;
		if (idle_cycles > 20000) begin
			$display("watchdog expired at %0t", $time);
			$display("Test completed with failures");
			$finish;
		end
	end

	task automatic add_row(input sample_t s, input logic known, input window_t w);
		row_t r;
		r.s = s;
		r.known = known;
		r.w = w;
		directed = {directed, r};
	endtask

	initial begin
		logic [31:0] now;
		int phase;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_ready = 1'b0;
		operation = OP_ACK;
		now_us = 0;
		rtt_us = 0;
		cwnd_in = 0;
		ssthresh_in = 0;
		segment_size = 0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = 0;
		pwdata = 0;
		errors = 0;
		no_idle = 1'b0;
		sending = 1'b0;
		phase_now = -1;
		idle_cycles = 0;
		n_acks = 0;
		n_wins = 0;
		n_congest = 0;
		p_init_thr = INIT_THR_RESET;
		p_time_win = TIME_WIN_RESET;
		p_min_rtt = 0;
		p_count = 0;
		p_head = 0;
		p_limit = LIMIT_RESET;
		p_dev = 0;
		p_cached = 0;
		p_last_comp = 0;
		p_last_ref = 0;
		p_thr = INIT_THR_RESET;
		foreach (p_hist[i])
			p_hist[i] = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table: op, now, rtt, cwnd, ssthresh, segment
		// window update right after reset, no congestion, zero deviation: +15 seg then +7 seg
		add_row({OP_WIN, 32'd0, 24'd0, 32'd1000, 32'd100000, 16'd100}, 1'b1,
			{32'd3200, 32'd100000, 1'b0, 32'd0});
		// unset minimum, nonzero rtt is high: congestion seen, zero severity keeps cwnd at ten segments
		add_row({OP_WIN, 32'd0, 24'd5, 32'd1000, 32'd100000, 16'd100}, 1'b1,
			{32'd1000, 32'd1000, 1'b1, 32'd0});
		// ack echoes inputs
		add_row({OP_ACK, 32'd0, 24'd1000, 32'hFFFF_FFFF, 32'd0, 16'hFFFF}, 1'b1,
			{32'hFFFF_FFFF, 32'd0, 1'b0, 32'd0});
		add_row({OP_ACK, 32'd20000, 24'hFFFFFF, 32'd0, 32'hFFFF_FFFF, 16'd0}, 1'b0, '0);
		add_row({OP_ACK, 32'hFFFF_FFFF, 24'd0, 32'd0, 32'd0, 16'd1}, 1'b0, '0);
		add_row({OP_ACK, 32'd40000, 24'd1050, 32'd0, 32'd0, 16'd1}, 1'b0, '0);
		add_row({OP_WIN, 32'd50000, 24'd0, 32'hFFFF_FFFF, 32'd0, 16'hFFFF}, 1'b0, '0);
		add_row({OP_WIN, 32'd50001, 24'd0, 32'd0, 32'hFFFF_FFFF, 16'd0}, 1'b0, '0);
		add_row({OP_WIN, 32'd60000, 24'd0, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 16'hFFFF}, 1'b0, '0);
		add_row({OP_WIN, 32'd60001, 24'd0, 32'd900, 32'd1000, 16'd50}, 1'b0, '0);
		add_row({OP_WIN, 32'd60002, 24'd0, 32'd1000, 32'd600, 16'd50}, 1'b0, '0);
		add_row({OP_WIN, 32'd60003, 24'd0, 32'd800, 32'd790, 16'd0}, 1'b0, '0);
		add_row({OP_WIN, 32'd60004, 24'd0, 32'd0, 32'd0, 16'd1}, 1'b0, '0);
		sending = 1'b1;
		foreach (directed[i])
			send_queue = {send_queue, directed[i].s};
		drain();
		sending = 1'b0;

		for (phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin
					write_register(REG_INIT_THR, 32'd1);
					write_register(REG_TIME_WIN, 32'd1);
				end
				1: begin
					write_register(REG_INIT_THR, 32'hFFFF_FFFF);
					write_register(REG_TIME_WIN, 32'hFFFF_FFFF);
				end
				2: begin
					write_register(REG_INIT_THR, $urandom_range(2000, 60000));
					write_register(REG_TIME_WIN, $urandom_range(1, 3000));
				end
				3: begin
					write_register(REG_INIT_THR, INIT_THR_RESET);
					write_register(REG_TIME_WIN, TIME_WIN_RESET);
				end
				default: begin
					write_register(REG_INIT_THR, $urandom_range(1, 600000));
					write_register(REG_TIME_WIN, $urandom_range(1, 20000));
				end
			endcase
			no_idle = (phase == 3);
			phase_now = phase;
			now = $urandom;
			for (int k = 0; k < 300; k++) begin
				now += $urandom_range(0, 4000);
				send_queue = {send_queue, random_sample(now)};
			end
			drain();
		end

		$display("%0d acks, %0d window updates, %0d with congestion cut", n_acks, n_wins,
			n_congest);
		$display("register extremes and stalls on both channels exercised");
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
